### hw/rtl/mqts_pkg.sv
// ----------------------------------------------------------------------------
// mqts_pkg
// Shared types, codes and helpers for the two-stack minimum queue.
// ----------------------------------------------------------------------------
package mqts_pkg;

	// operation codes carried in a request beat
	localparam logic [1:0] OP_QUERY = 2'd0;
	localparam logic [1:0] OP_ENQ   = 2'd1;
	localparam logic [1:0] OP_DEQ   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// status codes carried in a response beat
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	// minimum reported by an empty queue
	localparam logic signed [31:0] EMPTY_MIN = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] popped_value;
		logic [11:0]        item_count;
		logic signed [31:0] front_value;
		logic signed [31:0] min_value;
		logic               is_empty;
	} rsp_beat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_XFER,
		S_POP,
		S_REFILL,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic exec;    // request accepted: act on its op
		logic xfer;    // one step of the stack transfer
		logic pop;     // pop the output stack
		logic refill;  // capture the new output top from memory
		logic finish;  // load the response register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_zero;
		logic out_zero;
		logic out_one;
		logic xfer_done;
		logic rsp_free;
	} sts_t;

	function automatic logic signed [31:0] smin(input logic signed [31:0] a,
	                                            input logic signed [31:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

### hw/rtl/mqts_ram.sv
// ----------------------------------------------------------------------------
// mqts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mqts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/mqts_ctrl.sv
// ----------------------------------------------------------------------------
// mqts_ctrl
// Sequencer: accepts one request beat at a time and steps the datapath
// through transfer, pop, refill and response.
// ----------------------------------------------------------------------------
module mqts_ctrl
	import mqts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic [1:0] req_op,
	output logic      req_stall,
	input  sts_t      sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.exec = 1'b1;
					if (req_op == OP_DEQ && !(sts.in_zero && sts.out_zero)) begin
						state_d = sts.out_zero ? S_XFER : S_POP;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_XFER: begin
				if (sts.xfer_done) begin
					state_d = S_POP;
				end else begin
					cmd.xfer = 1'b1;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = sts.out_one ? S_FINISH : S_REFILL;
			end
			S_REFILL: begin
				cmd.refill = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (sts.rsp_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/mqts_dp.sv
// ----------------------------------------------------------------------------
// mqts_dp
// Datapath: stack depths, cached tops, stack memories and response register.
// ----------------------------------------------------------------------------
module mqts_dp
	import mqts_pkg::*;
#(
	parameter int STACK_DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_beat_t req,
	input  cmd_t      cmd,
	output sts_t      sts,
	input  logic      rsp_stall,
	output logic      rsp_valid,
	output rsp_beat_t rsp
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int CW = DW + 1;
	localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);

	// control state
	logic [DW-1:0] in_depth_q, out_depth_q;
	logic          rd_pend_q;
	logic          rsp_valid_q;

	// payload registers
	logic signed [31:0] in_bottom_q;   // oldest entry of the input stack
	logic signed [31:0] in_min_top_q;  // running minimum at input top
	logic signed [31:0] out_top_val_q;
	logic signed [31:0] out_top_min_q;
	logic signed [31:0] run_min_q;     // minimum of entries moved so far
	logic [1:0]         status_q;
	logic signed [31:0] popped_q;
	rsp_beat_t          rsp_q;

	// memory ports
	logic          in_we, in_re;
	logic [AW-1:0] in_waddr, in_raddr;
	logic [31:0]   in_rdata;
	logic          out_we, out_re;
	logic [AW-1:0] out_waddr, out_raddr;
	logic [31:0]   out_val_rdata, out_min_rdata;
	logic signed [31:0] xfer_val, xfer_min;

	logic in_zero, out_zero, in_full, is_enq;

	assign in_zero  = (in_depth_q == '0);
	assign out_zero = (out_depth_q == '0);
	assign in_full  = (in_depth_q == FULL_DEPTH);
	assign is_enq   = cmd.exec && (req.op == OP_ENQ);

	assign sts.in_zero   = in_zero;
	assign sts.out_zero  = out_zero;
	assign sts.out_one   = (out_depth_q == DW'(1));
	assign sts.xfer_done = in_zero && !rd_pend_q;
	assign sts.rsp_free  = !rsp_valid_q || !rsp_stall;

	// memory addressing
	assign in_we     = is_enq && !in_full;
	assign in_waddr  = in_depth_q[AW-1:0];
	assign in_re     = cmd.xfer && !in_zero;
	assign in_raddr  = AW'(in_depth_q - DW'(1));
	assign xfer_val  = $signed(in_rdata);
	assign xfer_min  = out_zero ? xfer_val : smin(xfer_val, run_min_q);
	assign out_we    = cmd.xfer && rd_pend_q;
	assign out_waddr = out_depth_q[AW-1:0];
	assign out_re    = cmd.pop && !sts.out_one;
	assign out_raddr = AW'(out_depth_q - DW'(2));

	mqts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_in_values (
		.clk  (clk),
		.we   (in_we),
		.waddr(in_waddr),
		.wdata(req.value),
		.re   (in_re),
		.raddr(in_raddr),
		.rdata(in_rdata)
	);

	mqts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_out_values (
		.clk  (clk),
		.we   (out_we),
		.waddr(out_waddr),
		.wdata(xfer_val),
		.re   (out_re),
		.raddr(out_raddr),
		.rdata(out_val_rdata)
	);

	mqts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_out_minima (
		.clk  (clk),
		.we   (out_we),
		.waddr(out_waddr),
		.wdata(xfer_min),
		.re   (out_re),
		.raddr(out_raddr),
		.rdata(out_min_rdata)
	);

	// depths, read pending flag and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_depth_q  <= '0;
			out_depth_q <= '0;
			rd_pend_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (in_we) begin
				in_depth_q <= in_depth_q + DW'(1);
			end
			if (cmd.exec && req.op == OP_CLEAR) begin
				in_depth_q  <= '0;
				out_depth_q <= '0;
			end
			if (cmd.xfer) begin
				rd_pend_q <= !in_zero;
				if (!in_zero) begin
					in_depth_q <= in_depth_q - DW'(1);
				end
				if (rd_pend_q) begin
					out_depth_q <= out_depth_q + DW'(1);
				end
			end
			if (cmd.pop) begin
				out_depth_q <= out_depth_q - DW'(1);
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// cached tops, status and popped value
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			popped_q <= '0;
			if (req.op == OP_ENQ && in_full) begin
				status_q <= STS_FULL;
			end else if (req.op == OP_DEQ && in_zero && out_zero) begin
				status_q <= STS_EMPTY;
			end else begin
				status_q <= STS_OK;
			end
		end
		if (in_we) begin
			in_min_top_q <= in_zero ? req.value : smin(req.value, in_min_top_q);
			if (in_zero) begin
				in_bottom_q <= req.value;
			end
		end
		if (out_we) begin
			run_min_q     <= xfer_min;
			out_top_val_q <= xfer_val;
			out_top_min_q <= xfer_min;
		end
		if (cmd.pop) begin
			popped_q <= out_top_val_q;
		end
		if (cmd.refill) begin
			out_top_val_q <= $signed(out_val_rdata);
			out_top_min_q <= $signed(out_min_rdata);
		end
	end

	// response beat
	logic [CW-1:0]      count;
	logic signed [31:0] front, min_in, min_all;

	always_comb begin
		count   = CW'(in_depth_q) + CW'(out_depth_q);
		front   = !out_zero ? out_top_val_q : (!in_zero ? in_bottom_q : 32'sd0);
		min_in  = !in_zero ? smin(EMPTY_MIN, in_min_top_q) : EMPTY_MIN;
		min_all = !out_zero ? smin(min_in, out_top_min_q) : min_in;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.status       <= status_q;
			rsp_q.popped_value <= popped_q;
			rsp_q.item_count   <= 12'(count);
			rsp_q.front_value  <= front;
			rsp_q.min_value    <= min_all;
			rsp_q.is_empty     <= (count == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hw/rtl/min_queue_two_stacks.sv
// ----------------------------------------------------------------------------
// min_queue_two_stacks
// FIFO of signed 32-bit values that reports its minimum, built on two stacks.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall/req) carries an op and a value; every
// request beat yields exactly one response beat (rsp_valid/rsp_stall/rsp)
// with status, dequeued value, count, front, minimum and an empty flag.
// One request is in work at a time; req_stall is high while it is.
// Steps from acceptance to response valid:
//   query, enqueue, clear, dequeue on an empty queue: finish
//   dequeue with the output stack holding one entry:  pop, finish
//   dequeue with the output stack holding more:       pop, refill, finish
//   dequeue with the output stack empty: first a transfer of the n input
//   entries, one per cycle, paced by the single read port of the input
//   stack memory, then as above.
// The response sits in an output register: the next request is accepted
// while it waits; when rsp_stall holds it, that request finishes its work
// and then waits in its final step until the register frees.
// Reset empties both stacks at once; memory contents need no clearing.
// ----------------------------------------------------------------------------
module min_queue_two_stacks
	import mqts_pkg::*;
#(
	parameter int STACK_DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	cmd_t cmd;
	sts_t sts;

	mqts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_op   (req.op),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mqts_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule

### tb/mqts_checker.sv
// ----------------------------------------------------------------------------
// mqts_checker
// Watches both channels of the two-stack minimum queue and checks every
// response beat against a local copy of the queue.
// ----------------------------------------------------------------------------
// Each accepted request beat is applied to the local copy, and the response
// it should produce is queued. Each accepted response beat is compared field
// by field with the oldest queued one. A response with nothing queued also
// counts as an error.
// ----------------------------------------------------------------------------
module mqts_checker
	import mqts_pkg::*;
#(
	parameter int STACK_DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_beat_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_beat_t rsp,
	output int        errors,
	output int        waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	// local copy of both stacks, value and running minimum per entry
	logic signed [31:0] in_val  [STACK_DEPTH];
	logic signed [31:0] in_min  [STACK_DEPTH];
	logic signed [31:0] out_val [STACK_DEPTH];
	logic signed [31:0] out_min [STACK_DEPTH];
	int unsigned        in_dep;
	int unsigned        out_dep;

	rsp_beat_t pending_rsp[$];
	int        rsp_no;

	function automatic logic signed [31:0] lower_of(input logic signed [31:0] a,
	                                               input logic signed [31:0] b);
		if (a < b)
			return a;
		return b;
	endfunction

	// apply one request to the local queue and work out its response
	function automatic rsp_beat_t queue_op_result(input req_beat_t r);
		rsp_beat_t          o;
		logic signed [31:0] v;
		o = '0;
		o.status = STS_OK;
		case (r.op)
			OP_ENQ: begin
				// full input stack refuses, whatever room the output stack has
				if (in_dep >= STACK_DEPTH) begin
					o.status = STS_FULL;
				end else begin
					in_val[in_dep] = r.value;
					in_min[in_dep] = (in_dep == 0) ? r.value : lower_of(r.value, in_min[in_dep - 1]);
					in_dep++;
				end
			end
			OP_DEQ: begin
				if (in_dep == 0 && out_dep == 0) begin
					o.status = STS_EMPTY;
				end else begin
					// refill the output stack top first, rebuilding minima
					if (out_dep == 0) begin
						while (in_dep > 0 && out_dep < STACK_DEPTH) begin
							in_dep--;
							v = in_val[in_dep];
							out_val[out_dep] = v;
							out_min[out_dep] = (out_dep == 0) ? v : lower_of(v, out_min[out_dep - 1]);
							out_dep++;
						end
					end
					out_dep--;
					o.popped_value = out_val[out_dep];
				end
			end
			OP_CLEAR: begin
				in_dep = 0;
				out_dep = 0;
			end
			default: ;
		endcase

		// snapshot of the queue after the op; query does no transfer
		o.item_count = 12'(in_dep + out_dep);
		if (out_dep > 0)
			o.front_value = out_val[out_dep - 1];
		else if (in_dep > 0)
			o.front_value = in_val[0];
		else
			o.front_value = '0;
		o.min_value = EMPTY_MIN;
		if (in_dep > 0)
			o.min_value = lower_of(o.min_value, in_min[in_dep - 1]);
		if (out_dep > 0)
			o.min_value = lower_of(o.min_value, out_min[out_dep - 1]);
		o.is_empty = (in_dep + out_dep == 0);
		return o;
	endfunction

	task automatic report_err(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
	                           input logic [31:0] want);
		if (got !== want)
			report_err($sformatf("response %0d %s got %0h want %0h", rsp_no, name, got, want));
	endtask

	// sample both channels at the edge; responses first, they are always older
	always @(posedge clk) begin : watch
		rsp_beat_t due;
		if (!arst_n) begin
			in_dep = 0;
			out_dep = 0;
			pending_rsp.delete();
			rsp_no = 0;
		end else begin
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (pending_rsp.size() == 0) begin
					report_err($sformatf("response %0d with no request waiting", rsp_no));
				end else begin
					due = pending_rsp.pop_front();
					check_field("status", rsp.status, due.status);
					check_field("popped_value", rsp.popped_value, due.popped_value);
					check_field("item_count", rsp.item_count, due.item_count);
					check_field("front_value", rsp.front_value, due.front_value);
					check_field("min_value", rsp.min_value, due.min_value);
					check_field("is_empty", rsp.is_empty, due.is_empty);
				end
				rsp_no++;
			end
			if (req_valid === 1'b1 && req_stall === 1'b0)
				pending_rsp.push_back(queue_op_result(req));
		end
		waiting = pending_rsp.size();
	end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the two-stack minimum queue.
// ----------------------------------------------------------------------------
// A short directed run covers empty dequeues, value extremes, fronts read
// from either stack and clears. Both stacks are then filled to refuse
// enqueues, followed by a random mix of ops. Both sides idle at random; the
// response side holds off once for a long stretch and the request side
// pauses twice until every response is back. mqts_checker does the checking.
// ----------------------------------------------------------------------------
module tb_top
	import mqts_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 1024;
	localparam int RAND_OPS    = 800;
	localparam int HOLD_CYCLES = 300;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_beat_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp;

	int errors;
	int waiting;
	int sent;
	int rsp_seen;

	min_queue_two_stacks #(
		.STACK_DEPTH(STACK_DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	mqts_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.waiting   (waiting)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// single reset at the start
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// hard stop if the run hangs
	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	// mostly short idle stretches, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(99) < 85)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// extremes, small values for ties, and full-range noise
	function automatic logic signed [31:0] rand_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return 32'sh8000_0000;
		if (r < 16)
			return 32'sh7FFF_FFFF;
		if (r < 40)
			return int'($urandom_range(16)) - 8;
		return $urandom;
	endfunction

	// count response beats taken, for the long hold-off trigger
	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall)
			rsp_seen <= rsp_seen + 1;

	// response side: random stalls, quiet windows, one long hold-off
	initial begin : rsp_side
		int  left;
		int  cyc;
		bit  held;
		left = 0;
		cyc = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && rsp_seen >= 150) begin
				held = 1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				left = 0;
			end
			if (left > 0) begin
				left--;
				rsp_stall <= 1'b1;
			end else if ((cyc % 400) < 80) begin
				rsp_stall <= 1'b0;
			end else if ($urandom_range(99) < 30) begin
				left = pick_gap() - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// offer one request beat and return at the edge that takes it
	task automatic send_beat(input logic [1:0] code, input logic signed [31:0] data);
		int gap;
		gap = 0;
		if ((sent % 300) >= 60 && $urandom_range(99) < 35)
			gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= '{op: code, value: data};
		req_valid <= 1'b1;
		// stall is stable mid-cycle, so judge acceptance there
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	// stop offering until every response is back
	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (waiting == 0);
		@(posedge clk);
	endtask

	initial begin : req_side
		logic [1:0]  code;
		int unsigned r;
		@(posedge arst_n);
		@(posedge clk);

		// directed: empty queue, extremes, fronts from each stack, clears
		send_beat(OP_QUERY, rand_value());
		send_beat(OP_DEQ, rand_value());
		send_beat(OP_ENQ, 32'sd0);
		send_beat(OP_ENQ, 32'sh7FFF_FFFF);
		send_beat(OP_ENQ, 32'sh8000_0000);
		send_beat(OP_ENQ, -32'sd1);
		send_beat(OP_QUERY, rand_value());
		send_beat(OP_DEQ, rand_value());
		send_beat(OP_ENQ, 32'sd5);
		send_beat(OP_QUERY, rand_value());
		send_beat(OP_DEQ, rand_value());
		send_beat(OP_DEQ, rand_value());
		send_beat(OP_DEQ, rand_value());
		send_beat(OP_QUERY, rand_value());
		send_beat(OP_DEQ, rand_value());
		send_beat(OP_DEQ, rand_value());
		send_beat(OP_ENQ, 32'sh5555_5555);
		send_beat(OP_ENQ, 32'shAAAA_AAAA);
		send_beat(OP_CLEAR, rand_value());
		send_beat(OP_QUERY, rand_value());
		send_beat(OP_DEQ, rand_value());
		send_beat(OP_ENQ, 32'sd1);
		send_beat(OP_ENQ, 32'sd1);
		send_beat(OP_CLEAR, rand_value());
		drain_responses();

		// fill the input stack and get refused with the output stack empty
		for (int i = 0; i < STACK_DEPTH; i++)
			send_beat(OP_ENQ, rand_value());
		send_beat(OP_ENQ, rand_value());
		// full transfer, then refill: refused with room on the output side
		send_beat(OP_DEQ, rand_value());
		for (int i = 0; i < STACK_DEPTH; i++)
			send_beat(OP_ENQ, rand_value());
		send_beat(OP_ENQ, rand_value());
		send_beat(OP_QUERY, rand_value());
		repeat (40)
			send_beat(OP_DEQ, rand_value());
		send_beat(OP_CLEAR, rand_value());

		// random mix, enqueue-heavy so the queue stays populated
		for (int n = 0; n < RAND_OPS; n++) begin
			if (n == RAND_OPS / 2)
				drain_responses();
			r = $urandom_range(99);
			if (r < 45)
				code = OP_ENQ;
			else if (r < 82)
				code = OP_DEQ;
			else if (r < 97)
				code = OP_QUERY;
			else
				code = OP_CLEAR;
			send_beat(code, rand_value());
		end

		// let everything come back, then a short tail for strays
		req_valid <= 1'b0;
		@(posedge clk);
		wait (waiting == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
